/* rtl/core/bpfs_pkg.sv */
`timescale 1ns / 1ps
// Shared types, widths and codes for the bordered pixel frame store.
package bpfs_pkg;

    // Field and register widths
    localparam int COORD_W    = 13;
    localparam int COLOUR_W   = 8;
    localparam int DIM_W      = 9;
    localparam int STRIDE_W   = 11;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 11;

    // Byte-packed pixels: blue, green, red
    localparam int BYTES_PER_PIXEL = 3;
    localparam int CHAN_W          = 2;
    localparam logic [CHAN_W-1:0] CHAN_LAST = CHAN_W'(BYTES_PER_PIXEL - 1);
    localparam logic [CHAN_W-1:0] CHAN_BLUE  = 2'd0;
    localparam logic [CHAN_W-1:0] CHAN_GREEN = 2'd1;
    localparam logic [CHAN_W-1:0] CHAN_RED   = 2'd2;

    // Signed stored row (height - 1 - row) and byte address arithmetic
    localparam int SROW_W  = 14;
    localparam int STEP_W  = 4;
    localparam int PROD_W  = STRIDE_W + DIM_W;
    localparam int BADDR_W = PROD_W + 1;

    // Stream payload layout
    localparam int S_TDATA_W = 56;
    localparam int S_TUSER_W = 1;
    localparam int M_TDATA_W = 24;
    localparam int M_TUSER_W = 1;
    localparam int COL_LSB   = 0;
    localparam int ROW_LSB   = COL_LSB + COORD_W;
    localparam int RED_LSB   = ROW_LSB + COORD_W;
    localparam int GREEN_LSB = RED_LSB + COLOUR_W;
    localparam int BLUE_LSB  = GREEN_LSB + COLOUR_W;

    // Fill values
    localparam logic [COLOUR_W-1:0] FILL_WHITE = 8'hFF;
    localparam logic [COLOUR_W-1:0] FILL_BLACK = 8'h00;

    // Register reset values
    localparam logic [DIM_W-1:0]    WIDTH_RST  = 9'd256;
    localparam logic [DIM_W-1:0]    HEIGHT_RST = 9'd256;
    localparam logic [STRIDE_W-1:0] STRIDE_RST = 11'd768;

    typedef enum logic [0:0] {
        CMD_READ  = 1'b0,
        CMD_WRITE = 1'b1
    } cmd_t;

    typedef enum logic [1:0] {
        BM_WRAP  = 2'd0,
        BM_WHITE = 2'd1,
        BM_BLACK = 2'd2,
        BM_NULL  = 2'd3
    } border_mode_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_IMAGE_WIDTH  = 2'd0,
        REG_IMAGE_HEIGHT = 2'd1,
        REG_ROW_STRIDE   = 2'd2,
        REG_BORDER_MODE  = 2'd3
    } cfg_index_t;

    // Controller to datapath commands
    typedef struct packed {
        logic clear_step;
        logic take_input;
        logic take_inside;
        logic fill;
        logic div_start;
        logic div_sel_y;
        logic take_x;
        logic take_y;
        logic mul;
        logic addr;
        logic access;
        logic out_load;
    } dp_cmd_t;

    // Datapath to controller status
    typedef struct packed {
        logic clear_last;
        logic is_write;
        logic in_image;
        logic wrap_ok;
        logic div_done;
        logic chan_last;
        logic out_free;
    } dp_status_t;

endpackage

/* rtl/core/bordered_pixel_frame_store_core.sv */
`timescale 1ns / 1ps
// An inside read: classify, multiply, address, three byte accesses, read wait, response;
// a wrap read first runs two 14-step modulo passes; an outside fill read goes straight to the
// response. An inside write ends after its three byte accesses; an outside write is dropped.
// Throughput: one transaction at a time, the next waiting on the serial modulo unit, the three
// byte accesses and a stalled result. Reset (synchronous, aresetn low) restores the registers,
// then zeroes MAX_ROW_BYTES * MAX_ROWS bytes (262144 by default), one per cycle, s_tready low.
module bordered_pixel_frame_store_core #(
    parameter int MAX_ROW_BYTES = 1024,
    parameter int MAX_ROWS      = 256
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    // Configuration write port
    input  logic                              cfg_wr_en,
    input  logic [bpfs_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [bpfs_pkg::CFG_DATA_W-1:0]   cfg_wdata,
    // Input stream
    input  logic                              s_tvalid,
    output logic                              s_tready,
    // s_tdata: col[12:0], row[25:13], red_in[33:26], green_in[41:34], blue_in[49:42], zeros
    input  logic [bpfs_pkg::S_TDATA_W-1:0]    s_tdata,
    // s_tuser: command[0]
    input  logic [bpfs_pkg::S_TUSER_W-1:0]    s_tuser,
    // Result stream
    output logic                              m_tvalid,
    input  logic                              m_tready,
    // m_tdata: red_out[7:0], green_out[15:8], blue_out[23:16]
    output logic [bpfs_pkg::M_TDATA_W-1:0]    m_tdata,
    // m_tuser: pixel_valid[0]
    output logic [bpfs_pkg::M_TUSER_W-1:0]    m_tuser
);
    import bpfs_pkg::*;

    localparam int RAM_DEPTH = MAX_ROW_BYTES * MAX_ROWS;

    dp_cmd_t    cmd;
    dp_status_t status;

    bpfs_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .status   (status),
        .cmd      (cmd)
    );

    bpfs_datapath #(
        .RAM_DEPTH (RAM_DEPTH)
    ) u_datapath (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .cmd       (cmd),
        .status    (status)
    );

endmodule

/* rtl/core/bpfs_ram.sv */
`timescale 1ns / 1ps
// Generic single-port RAM with registered read data.
module bpfs_ram #(
    parameter int WIDTH  = 8,
    parameter int DEPTH  = 262144,
    parameter int ADDR_W = $clog2(DEPTH)
) (
    input  logic              aclk,
    input  logic              we,
    input  logic [ADDR_W-1:0] addr,
    input  logic [WIDTH-1:0]  wdata,
    output logic [WIDTH-1:0]  rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // One access per cycle: a write when enabled, and always a registered read of the old contents.
    always_ff @(posedge aclk) begin
        if (we) begin
            mem[addr] <= wdata;
        end
        rdata_reg <= mem[addr];
    end

    assign rdata = rdata_reg;

endmodule

/* rtl/core/bpfs_rem.sv */
`timescale 1ns / 1ps
// Iterative positive-modulo unit: one restoring step per cycle.
module bpfs_rem (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         start,
    input  logic [bpfs_pkg::SROW_W-1:0]  dividend_mag,
    input  logic                         dividend_neg,
    input  logic [bpfs_pkg::DIM_W-1:0]   divisor,
    output logic                         done,
    output logic [bpfs_pkg::DIM_W-1:0]   result
);
    import bpfs_pkg::*;

    localparam logic [STEP_W-1:0] STEP_LAST = STEP_W'(SROW_W - 1);

    logic                busy_reg, busy_next;
    logic                done_reg, done_next;
    logic [STEP_W-1:0]   step_reg, step_next;
    logic [SROW_W-1:0]   dvd_reg;
    logic [DIM_W-1:0]    rem_reg;
    logic [DIM_W-1:0]    dsr_reg;
    logic                neg_reg;
    logic [DIM_W:0]      trial;
    logic [DIM_W:0]      diff;
    logic [DIM_W-1:0]    rem_step;

    // Shift in the next dividend bit and subtract the divisor where it fits.
    assign trial    = {rem_reg, dvd_reg[SROW_W-1]};
    assign diff     = trial - {1'b0, dsr_reg};
    assign rem_step = (trial >= {1'b0, dsr_reg}) ? diff[DIM_W-1:0] : trial[DIM_W-1:0];

    // Step sequencing.
    always_comb begin
        busy_next = busy_reg;
        step_next = step_reg;
        done_next = 1'b0;
        if (start && !busy_reg) begin
            busy_next = 1'b1;
            step_next = '0;
        end else if (busy_reg) begin
            step_next = step_reg + 1'b1;
            if (step_reg == STEP_LAST) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= '0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            step_reg <= step_next;
        end
    end

    // Operand and partial remainder registers.
    always_ff @(posedge aclk) begin
        if (start && !busy_reg) begin
            dvd_reg <= dividend_mag;
            rem_reg <= '0;
            dsr_reg <= divisor;
            neg_reg <= dividend_neg;
        end else if (busy_reg) begin
            dvd_reg <= {dvd_reg[SROW_W-2:0], 1'b0};
            rem_reg <= rem_step;
        end
    end

    // A negative dividend with a non-zero remainder folds back into range.
    assign result = (neg_reg && (rem_reg != '0)) ? (dsr_reg - rem_reg) : rem_reg;
    assign done   = done_reg;

endmodule

/* rtl/core/bpfs_datapath.sv */
`timescale 1ns / 1ps
// Datapath: configuration, coordinate handling, address arithmetic, store and output.
module bpfs_datapath #(
    parameter int RAM_DEPTH = 262144
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              cfg_wr_en,
    input  logic [bpfs_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [bpfs_pkg::CFG_DATA_W-1:0]   cfg_wdata,
    input  logic [bpfs_pkg::S_TDATA_W-1:0]    s_tdata,
    input  logic [bpfs_pkg::S_TUSER_W-1:0]    s_tuser,
    output logic                              m_tvalid,
    input  logic                              m_tready,
    output logic [bpfs_pkg::M_TDATA_W-1:0]    m_tdata,
    output logic [bpfs_pkg::M_TUSER_W-1:0]    m_tuser,
    input  bpfs_pkg::dp_cmd_t                 cmd,
    output bpfs_pkg::dp_status_t              status
);
    import bpfs_pkg::*;

    localparam int RAM_AW = (RAM_DEPTH > 1) ? $clog2(RAM_DEPTH) : 1;
    localparam logic [31:0]       RAM_DEPTH_L = 32'(RAM_DEPTH);
    localparam logic [RAM_AW-1:0] CLR_LAST    = RAM_AW'(RAM_DEPTH - 1);

    // Configuration registers
    logic [DIM_W-1:0]    image_width_reg;
    logic [DIM_W-1:0]    image_height_reg;
    logic [STRIDE_W-1:0] row_stride_reg;
    border_mode_t        border_mode_reg;

    // Captured transaction
    cmd_t                       cmd_reg;
    logic signed [COORD_W-1:0]  col_reg;
    logic signed [COORD_W-1:0]  row_reg;
    logic [COLOUR_W-1:0]        red_reg, green_reg, blue_reg;

    // Address path
    logic [DIM_W-1:0]    cx_reg, cy_reg;
    logic [PROD_W-1:0]   prod_reg;
    logic [BADDR_W-1:0]  base_reg;
    logic [CHAN_W-1:0]   chan_reg;
    logic [RAM_AW-1:0]   clr_addr_reg;

    // Read capture and result
    logic                rd_pend_reg;
    logic [CHAN_W-1:0]   rd_chan_reg;
    logic                rd_ok_reg;
    logic [COLOUR_W-1:0] pix_red_reg, pix_green_reg, pix_blue_reg;
    logic                pix_valid_reg;
    logic                m_tvalid_reg;
    logic [M_TDATA_W-1:0] m_tdata_reg;
    logic                m_tuser_reg;

    logic signed [SROW_W-1:0] col_s, row_s, height_s, srow_s, div_val;
    logic                     col_inside, row_inside, in_image;
    logic [SROW_W-1:0]        div_mag;
    logic [DIM_W-1:0]         div_divisor;
    logic [DIM_W-1:0]         rem_result;
    logic                     rem_done;
    logic                     is_write;
    logic [31:0]              full_addr;
    logic                     in_range;
    logic                     ram_we;
    logic [RAM_AW-1:0]        ram_addr;
    logic [COLOUR_W-1:0]      ram_wdata, ram_rdata, wr_byte;
    logic [COLOUR_W-1:0]      fill_byte;
    logic                     fill_valid;

    // Configuration writes
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            image_width_reg  <= WIDTH_RST;
            image_height_reg <= HEIGHT_RST;
            row_stride_reg   <= STRIDE_RST;
            border_mode_reg  <= BM_BLACK;
        end else if (cfg_wr_en) begin
            case (cfg_index_t'(cfg_index))
                REG_IMAGE_WIDTH:  image_width_reg  <= cfg_wdata[DIM_W-1:0];
                REG_IMAGE_HEIGHT: image_height_reg <= cfg_wdata[DIM_W-1:0];
                REG_ROW_STRIDE:   row_stride_reg   <= cfg_wdata[STRIDE_W-1:0];
                REG_BORDER_MODE:  border_mode_reg  <= border_mode_t'(cfg_wdata[1:0]);
                default: ;
            endcase
        end
    end

    // Capture of the input transaction
    always_ff @(posedge aclk) begin
        if (cmd.take_input) begin
            cmd_reg   <= cmd_t'(s_tuser[0]);
            col_reg   <= s_tdata[COL_LSB +: COORD_W];
            row_reg   <= s_tdata[ROW_LSB +: COORD_W];
            red_reg   <= s_tdata[RED_LSB +: COLOUR_W];
            green_reg <= s_tdata[GREEN_LSB +: COLOUR_W];
            blue_reg  <= s_tdata[BLUE_LSB +: COLOUR_W];
        end
    end

    // Row flip and strict inside test
    assign col_s    = {col_reg[COORD_W-1], col_reg};
    assign row_s    = {row_reg[COORD_W-1], row_reg};
    assign height_s = $signed({{(SROW_W - DIM_W){1'b0}}, image_height_reg});
    assign srow_s   = height_s - 14'sd1 - row_s;

    assign col_inside = !col_reg[COORD_W-1] &&
                        ({1'b0, col_reg[COORD_W-2:0]} < {4'b0, image_width_reg});
    assign row_inside = !row_reg[COORD_W-1] &&
                        ({1'b0, row_reg[COORD_W-2:0]} < {4'b0, image_height_reg});
    assign in_image   = col_inside && row_inside;
    assign is_write   = (cmd_reg == CMD_WRITE);

    // Operand selection for the shared modulo unit
    assign div_val     = cmd.div_sel_y ? srow_s : col_s;
    assign div_mag     = div_val[SROW_W-1] ? (SROW_W'(0) - $unsigned(div_val))
                                           : $unsigned(div_val);
    assign div_divisor = cmd.div_sel_y ? image_height_reg : image_width_reg;

    bpfs_rem u_rem (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .start        (cmd.div_start),
        .dividend_mag (div_mag),
        .dividend_neg (div_val[SROW_W-1]),
        .divisor      (div_divisor),
        .done         (rem_done),
        .result       (rem_result)
    );

    // Pixel coordinates, row product and base byte address
    always_ff @(posedge aclk) begin
        if (cmd.take_inside) begin
            cx_reg <= col_reg[DIM_W-1:0];
            cy_reg <= srow_s[DIM_W-1:0];
        end
        if (cmd.take_x) begin
            cx_reg <= rem_result;
        end
        if (cmd.take_y) begin
            cy_reg <= rem_result;
        end
        if (cmd.mul) begin
            prod_reg <= PROD_W'(row_stride_reg) * PROD_W'(cy_reg);
        end
        if (cmd.addr) begin
            base_reg <= BADDR_W'(prod_reg) + BADDR_W'({cx_reg, 1'b0}) + BADDR_W'(cx_reg);
        end
    end

    // Channel counter and clearing sweep counter
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            chan_reg     <= '0;
            clr_addr_reg <= '0;
            rd_pend_reg  <= 1'b0;
        end else begin
            if (cmd.addr) begin
                chan_reg <= '0;
            end else if (cmd.access) begin
                chan_reg <= chan_reg + 1'b1;
            end
            if (cmd.clear_step) begin
                clr_addr_reg <= clr_addr_reg + 1'b1;
            end
            rd_pend_reg <= cmd.access && !is_write;
        end
    end

    // Byte address of the current channel and range check against the store
    assign full_addr = 32'(base_reg) + 32'(chan_reg);
    assign in_range  = (full_addr < RAM_DEPTH_L);

    always_comb begin
        case (chan_reg)
            CHAN_BLUE:  wr_byte = blue_reg;
            CHAN_GREEN: wr_byte = green_reg;
            CHAN_RED:   wr_byte = red_reg;
            default:    wr_byte = blue_reg;
        endcase
    end

    assign ram_we    = cmd.clear_step || (cmd.access && is_write && in_range);
    assign ram_addr  = cmd.clear_step ? clr_addr_reg : full_addr[RAM_AW-1:0];
    assign ram_wdata = cmd.clear_step ? FILL_BLACK : wr_byte;

    bpfs_ram #(
        .WIDTH  (COLOUR_W),
        .DEPTH  (RAM_DEPTH),
        .ADDR_W (RAM_AW)
    ) u_store (
        .aclk  (aclk),
        .we    (ram_we),
        .addr  (ram_addr),
        .wdata (ram_wdata),
        .rdata (ram_rdata)
    );

    // Fill value for reads outside the image
    always_comb begin
        case (border_mode_reg)
            BM_WHITE: begin
                fill_byte  = FILL_WHITE;
                fill_valid = 1'b1;
            end
            BM_NULL: begin
                fill_byte  = FILL_BLACK;
                fill_valid = 1'b0;
            end
            BM_WRAP, BM_BLACK: begin
                fill_byte  = FILL_BLACK;
                fill_valid = 1'b1;
            end
            default: begin
                fill_byte  = FILL_BLACK;
                fill_valid = 1'b1;
            end
        endcase
    end

    // Pixel assembly: registered read data lands in the cycle after its address
    always_ff @(posedge aclk) begin
        if (cmd.access) begin
            rd_chan_reg <= chan_reg;
            rd_ok_reg   <= in_range;
        end
        if (cmd.fill) begin
            pix_red_reg   <= fill_byte;
            pix_green_reg <= fill_byte;
            pix_blue_reg  <= fill_byte;
            pix_valid_reg <= fill_valid;
        end
        if (cmd.addr) begin
            pix_valid_reg <= 1'b1;
        end
        if (rd_pend_reg) begin
            case (rd_chan_reg)
                CHAN_BLUE:  pix_blue_reg  <= rd_ok_reg ? ram_rdata : FILL_BLACK;
                CHAN_GREEN: pix_green_reg <= rd_ok_reg ? ram_rdata : FILL_BLACK;
                CHAN_RED:   pix_red_reg   <= rd_ok_reg ? ram_rdata : FILL_BLACK;
                default: ;
            endcase
        end
    end

    // Output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (cmd.out_load) begin
            m_tvalid_reg <= 1'b1;
        end else if (m_tready) begin
            m_tvalid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.out_load) begin
            m_tdata_reg <= {pix_blue_reg, pix_green_reg, pix_red_reg};
            m_tuser_reg <= pix_valid_reg;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;

    assign status.clear_last = (clr_addr_reg == CLR_LAST);
    assign status.is_write   = is_write;
    assign status.in_image   = in_image;
    assign status.wrap_ok    = (border_mode_reg == BM_WRAP) &&
                               (image_width_reg != '0) && (image_height_reg != '0);
    assign status.div_done   = rem_done;
    assign status.chan_last  = (chan_reg == CHAN_LAST);
    assign status.out_free   = !m_tvalid_reg || m_tready;

endmodule

/* rtl/core/bpfs_ctrl.sv */
`timescale 1ns / 1ps
// Controller state machine: sequences clearing, classification, modulo, address, access and response.
module bpfs_ctrl (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  bpfs_pkg::dp_status_t  status,
    output bpfs_pkg::dp_cmd_t     cmd
);
    import bpfs_pkg::*;

    typedef enum logic [9:0] {
        ST_CLEAR    = 10'b00_0000_0001,
        ST_IDLE     = 10'b00_0000_0010,
        ST_CLASSIFY = 10'b00_0000_0100,
        ST_DIV_X    = 10'b00_0000_1000,
        ST_DIV_Y    = 10'b00_0001_0000,
        ST_MUL      = 10'b00_0010_0000,
        ST_ADDR     = 10'b00_0100_0000,
        ST_ACCESS   = 10'b00_1000_0000,
        ST_RD_WAIT  = 10'b01_0000_0000,
        ST_RESP     = 10'b10_0000_0000
    } state_t;

    state_t state_reg, state_next;

    // Next state and command decode
    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        s_tready   = 1'b0;
        case (state_reg)
            ST_CLEAR: begin
                cmd.clear_step = 1'b1;
                if (status.clear_last) begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE: begin
                s_tready = 1'b1;
                if (s_tvalid) begin
                    cmd.take_input = 1'b1;
                    state_next     = ST_CLASSIFY;
                end
            end
            ST_CLASSIFY: begin
                if (status.in_image) begin
                    cmd.take_inside = 1'b1;
                    state_next      = ST_MUL;
                end else if (status.is_write) begin
                    state_next = ST_IDLE;
                end else if (status.wrap_ok) begin
                    cmd.div_start = 1'b1;
                    state_next    = ST_DIV_X;
                end else begin
                    cmd.fill   = 1'b1;
                    state_next = ST_RESP;
                end
            end
            ST_DIV_X: begin
                if (status.div_done) begin
                    cmd.take_x    = 1'b1;
                    cmd.div_start = 1'b1;
                    cmd.div_sel_y = 1'b1;
                    state_next    = ST_DIV_Y;
                end
            end
            ST_DIV_Y: begin
                if (status.div_done) begin
                    cmd.take_y = 1'b1;
                    state_next = ST_MUL;
                end
            end
            ST_MUL: begin
                cmd.mul    = 1'b1;
                state_next = ST_ADDR;
            end
            ST_ADDR: begin
                cmd.addr   = 1'b1;
                state_next = ST_ACCESS;
            end
            ST_ACCESS: begin
                cmd.access = 1'b1;
                if (status.chan_last) begin
                    state_next = status.is_write ? ST_IDLE : ST_RD_WAIT;
                end
            end
            ST_RD_WAIT: begin
                state_next = ST_RESP;
            end
            ST_RESP: begin
                if (status.out_free) begin
                    cmd.out_load = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_CLEAR;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_CLEAR;
        end else begin
            state_reg <= state_next;
        end
    end

endmodule

/* rtl/core/bpfs_checker.sv */
`timescale 1ns / 1ps
// Port-level checker for the frame store core and its bind.
module bpfs_checker (
    input logic                              aclk,
    input logic                              aresetn,
    input logic                              s_tvalid,
    input logic                              s_tready,
    input logic [bpfs_pkg::M_TDATA_W-1:0]    m_tdata,
    input logic [bpfs_pkg::M_TUSER_W-1:0]    m_tuser,
    input logic                              m_tvalid,
    input logic                              m_tready
);
    import bpfs_pkg::*;

    // Reset empties the output register and starts the clearing sweep.
    a_reset_idle: assert property (@(posedge aclk)
        !aresetn |=> (!m_tvalid && !s_tready))
        else $error("output valid or input ready after reset");

    // A stalled result holds.
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata) && $stable(m_tuser)))
        else $error("stalled result changed");

    // A pixel marked not valid carries zero colour bytes.
    a_null_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && (m_tuser == 1'b0)) |-> (m_tdata == '0))
        else $error("null result with non-zero colour");

    // One transaction at a time: ready drops after every acceptance.
    a_one_at_a_time: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready) |=> !s_tready)
        else $error("input accepted on consecutive cycles");

endmodule

bind bordered_pixel_frame_store_core bpfs_checker u_bpfs_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready)
);
